>>> rtl/aes_kexp_pkg.sv
// Shared types, constants and functions for the AES-128 key expansion block.
// Holds the S-box table, GF(2^8) doubling and the one-round key step.
// No dependencies.
package aes_kexp_pkg;

    localparam int KEY_W          = 128;
    localparam int HALF_W         = 64;
    localparam int WORD_W         = 32;
    localparam int BYTE_W         = 8;
    localparam int ROUND_W        = 4;
    localparam int ROUNDS_DEFAULT = 10;

    localparam logic [BYTE_W-1:0] RCON_INIT = 8'h01;
    localparam logic [BYTE_W-1:0] GF_POLY   = 8'h1b;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // Per-cell handshake from the chain control: take a key, or hand the held key on.
    typedef struct packed {
        logic load;
        logic emit;
    } cell_ctrl_t;

    localparam byte_t SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic byte_t gf_double(input byte_t v);
        return {v[BYTE_W-2:0], 1'b0} ^ (v[BYTE_W-1] ? GF_POLY : '0);
    endfunction

    // Round constant used when stepping from round n to round n+1.
    function automatic byte_t rcon_at(input int unsigned n);
        byte_t r;
        r = RCON_INIT;
        for (int unsigned i = 0; i < n; i++) begin
            r = gf_double(r);
        end
        return r;
    endfunction

    function automatic word_t sub_word(input word_t w);
        word_t r;
        for (int b = 0; b < WORD_W / BYTE_W; b++) begin
            r[b*BYTE_W +: BYTE_W] = SBOX[w[b*BYTE_W +: BYTE_W]];
        end
        return r;
    endfunction

    // One key-schedule round; word 0 sits in the top 32 bits of the key.
    function automatic key_t expand_key(input key_t k, input byte_t rcon);
        word_t w0, w1, w2, w3, t, n0, n1, n2, n3;
        w0 = k[4*WORD_W-1:3*WORD_W];
        w1 = k[3*WORD_W-1:2*WORD_W];
        w2 = k[2*WORD_W-1:WORD_W];
        w3 = k[WORD_W-1:0];
        t  = sub_word({w3[WORD_W-BYTE_W-1:0], w3[WORD_W-1:WORD_W-BYTE_W]});
        t  = t ^ {rcon, {(WORD_W-BYTE_W){1'b0}}};
        n0 = w0 ^ t;
        n1 = w1 ^ n0;
        n2 = w2 ^ n1;
        n3 = w3 ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage

>>> rtl/aes_kexp_cell.sv
// One cell of the key-schedule chain: holds one round key and offers the next.
// Depends on aes_kexp_pkg.
module aes_kexp_cell #(
    parameter logic [7:0] RCON    = aes_kexp_pkg::RCON_INIT,
    parameter bit         IS_LAST = 1'b0
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  aes_kexp_pkg::cell_ctrl_t  ctrl,
    input  aes_kexp_pkg::key_t        load_key,
    output logic                      valid,
    output aes_kexp_pkg::key_t        key,
    output aes_kexp_pkg::key_t        next_key
);

    logic               valid_reg, valid_next;
    aes_kexp_pkg::key_t key_reg;

    always_comb begin
        valid_next = valid_reg;
        if (ctrl.emit) begin
            valid_next = 1'b0;
        end
        if (ctrl.load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            key_reg <= load_key;
        end
    end

    assign valid = valid_reg;
    assign key   = key_reg;

    // The final round key is never stepped further.
    generate
        if (IS_LAST) begin : g_last
            assign next_key = '0;
        end else begin : g_step
            assign next_key = aes_kexp_pkg::expand_key(key_reg, RCON);
        end
    endgenerate

endmodule

>>> rtl/aes128_key_expansion.sv
// AES-128 key expansion: a chain of ROUNDS+1 cells, cell k holding round key k.
// Round key k leaves cell k for the m_ output register as the item steps on into cell k+1;
// an item taken while the previous one drains waits in cell 0 until that one has left cell ROUNDS.
// Output: one round key per cycle while m_ does not stall; a new key may enter cell 0 meanwhile.
// Reset clears the cell valid bits and the output valid; key registers are not reset.
// Depends on aes_kexp_pkg and aes_kexp_cell.
module aes128_key_expansion #(
    parameter int ROUNDS = aes_kexp_pkg::ROUNDS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // key_high [63:0], key_low [127:64]
    input  logic [aes_kexp_pkg::KEY_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // round_key_high [63:0], round_key_low [127:64]
    output logic [aes_kexp_pkg::KEY_W-1:0]     m_tdata,
    // round_index [3:0]
    output logic [aes_kexp_pkg::ROUND_W-1:0]   m_tuser,
    output logic                               m_tlast
);

    localparam int HW = aes_kexp_pkg::HALF_W;

    aes_kexp_pkg::cell_ctrl_t ctrl [ROUNDS+1];
    aes_kexp_pkg::key_t       cell_key [ROUNDS+1];
    aes_kexp_pkg::key_t       cell_next [ROUNDS+1];
    logic [ROUNDS:0]          cell_v;
    logic [ROUNDS:0]          emit;
    logic                     out_free;
    logic                     s_accept;
    aes_kexp_pkg::key_t       in_key;

    logic                               m_valid_reg, m_valid_next;
    aes_kexp_pkg::key_t                 m_key_reg, m_key_next;
    logic [aes_kexp_pkg::ROUND_W-1:0]   m_round_reg, m_round_next;
    logic                               m_last_reg, m_last_next;

    assign out_free = !m_valid_reg || m_tready;
    // Internal key order puts word 0 on top.
    assign in_key   = {s_tdata[HW-1:0], s_tdata[2*HW-1:HW]};

    // The highest-numbered valid cell holds the oldest item and owns the output.
    always_comb begin
        logic found;
        found = 1'b0;
        for (int k = ROUNDS; k >= 0; k--) begin
            emit[k] = out_free && cell_v[k] && !found;
            found   = found || cell_v[k];
        end
    end

    assign s_tready = !cell_v[0] || emit[0];
    assign s_accept = s_tvalid && s_tready;

    genvar g;
    generate
        for (g = 0; g <= ROUNDS; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign ctrl[g].load = s_accept;
            end else begin : g_body
                assign ctrl[g].load = emit[g-1];
            end
            assign ctrl[g].emit = emit[g];

            aes_kexp_cell #(
                .RCON    (aes_kexp_pkg::rcon_at(g)),
                .IS_LAST (g == ROUNDS)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl[g]),
                .load_key ((g == 0) ? in_key : cell_next[(g == 0) ? 0 : g-1]),
                .valid    (cell_v[g]),
                .key      (cell_key[g]),
                .next_key (cell_next[g])
            );
        end
    endgenerate

    always_comb begin
        m_valid_next = m_valid_reg;
        m_key_next   = '0;
        m_round_next = '0;
        m_last_next  = emit[ROUNDS];
        for (int k = 0; k <= ROUNDS; k++) begin
            if (emit[k]) begin
                m_key_next   = m_key_next | cell_key[k];
                m_round_next = m_round_next | aes_kexp_pkg::ROUND_W'(k);
            end
        end
        if (out_free) begin
            m_valid_next = |emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (|emit) begin
            m_key_reg   <= m_key_next;
            m_round_reg <= m_round_next;
            m_last_reg  <= m_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_key_reg[HW-1:0], m_key_reg[2*HW-1:HW]};
    assign m_tuser  = m_round_reg;
    assign m_tlast  = m_last_reg;

    // Only one cell may hand its key to the output register in a cycle.
    a_emit_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(emit))
        else $error("more than one cell emitting");

    // Beyond the head cell, at most one item is in flight.
    a_single_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cell_v[ROUNDS:1]))
        else $error("two items in the chain body");

    // A key leaving the head cell lands in cell 1 and on the output.
    a_head_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        emit[0] |=> (cell_v[1] && m_tvalid && m_tuser == '0))
        else $error("round 0 key not advanced");

    // The flagged key is always the final round.
    a_last_round: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == aes_kexp_pkg::ROUND_W'(ROUNDS)))
        else $error("last flag on wrong round");

endmodule
